// ----- hdl/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths, flag positions and register indexes of the sub-volume
// address walker.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int COORD_BITS = 10;
    localparam int ADDR_BITS  = 32;

    localparam int CFG_W      = 3 * COORD_BITS;
    localparam int FLAG_W     = 6;

    // Input payload: start_x, start_y, start_z, start_addr.
    localparam int IN_RAW_W   = 3 * COORD_BITS + ADDR_BITS;
    localparam int IN_W       = ((IN_RAW_W + 7) / 8) * 8;
    // Output payload: cur_x, cur_y, cur_z, cur_addr, edge_flags.
    localparam int OUT_RAW_W  = 3 * COORD_BITS + ADDR_BITS + FLAG_W;
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [FLAG_W-1:0]     t_flags;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME_SIZE  = 2'd0,
        CFG_REGION_BEGIN = 2'd1,
        CFG_REGION_END   = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    localparam int F_XLOW  = 0;
    localparam int F_XHIGH = 1;
    localparam int F_YLOW  = 2;
    localparam int F_YHIGH = 3;
    localparam int F_ZLOW  = 4;
    localparam int F_ZHIGH = 5;

    // Mode carried in tuser.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

endpackage

// ----- hdl/subvolume_address_walker_unit.sv -----
// ----------------------------------------------------------------------------
// subvolume_address_walker_unit
// Walks a box inside a volume in x, y, z order and reports position,
// linear address and volume-face flags for every item.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command item: tuser is the mode (load or
// advance), tdata the start position and address used by a load. For each
// accepted item one result item leaves on the master stream with the
// position, address and edge flags after that item; tuser flags an advance
// that was refused because x already stood at or past the box end.
// The configuration channel writes the volume size, box begin and box end
// registers; it is always ready and should be used only while the walker
// is idle.
// A result is valid in the cycle after its item is accepted. One item is
// accepted in every cycle while the receiver takes the results: the next
// state and the result are computed by a single pass of logic from the
// state registers, whose longest path is the address adder chain and, on a
// load, the slice stride multiplier. When the receiver stalls, the result
// stays in the output register and a new item is accepted only in the
// cycle the held result is taken. Reset clears the position, address,
// flags, strides and registers and empties the output register.
// ----------------------------------------------------------------------------
module subvolume_address_walker_unit
    import swa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Command stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,  // start_x, start_y, start_z, start_addr
    input  logic [0:0]           i_s_axis_tuser,  // mode
    // Result stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,  // cur_x, cur_y, cur_z, cur_addr, edge_flags
    output logic [0:0]           o_m_axis_tuser   // step_error
);

    localparam int C = COORD_BITS;
    localparam int A = ADDR_BITS;

    logic [CFG_W-1:0] r_size, r_begin, r_end;

    t_coord r_pos_x, r_pos_y, r_pos_z;
    t_addr  r_addr, r_row_skip, r_slice_skip;
    t_flags r_edge;

    t_coord n_pos_x, n_pos_y, n_pos_z;
    t_addr  n_addr, n_row_skip, n_slice_skip;
    t_flags n_edge;
    logic   n_err;

    logic   r_out_valid;
    t_coord r_out_x, r_out_y, r_out_z;
    t_addr  r_out_addr;
    t_flags r_out_edge;
    logic   r_out_err;

    logic   in_accept;
    logic   cfg_accept;

    t_coord sx, sy, sz, bx, by, ex, ey, ez;
    t_coord st_x, st_y, st_z;
    t_addr  st_addr;
    logic   mode;

    assign sx = r_size[C-1:0];
    assign sy = r_size[2*C-1:C];
    assign sz = r_size[3*C-1:2*C];
    assign bx = r_begin[C-1:0];
    assign by = r_begin[2*C-1:C];
    assign ex = r_end[C-1:0];
    assign ey = r_end[2*C-1:C];
    assign ez = r_end[3*C-1:2*C];

    assign st_x    = i_s_axis_tdata[C-1:0];
    assign st_y    = i_s_axis_tdata[2*C-1:C];
    assign st_z    = i_s_axis_tdata[3*C-1:2*C];
    assign st_addr = i_s_axis_tdata[3*C+A-1:3*C];
    assign mode    = i_s_axis_tuser[0];

    assign o_cfg_ready     = 1'b1;
    assign cfg_accept      = i_cfg_valid & o_cfg_ready;
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;

    // Strides taken from the registers at a load. The coordinate differences
    // wrap in the address width, as the box extent may be negative.
    t_addr            dx_a, dy_a, sy_minus_dy;
    logic [A+C-1:0]   slice_prod;

    assign dx_a        = t_addr'(ex) - t_addr'(bx);
    assign dy_a        = t_addr'(ey) - t_addr'(by);
    assign sy_minus_dy = t_addr'(sy) - dy_a;
    assign slice_prod  = sy_minus_dy * sx;

    always_comb begin
        t_coord nx, ny, nz, ez1;
        logic   row_wrap, y_step, slice_wrap, z_step, z_done;

        nx         = r_pos_x + t_coord'(1);
        ny         = r_pos_y + t_coord'(1);
        nz         = r_pos_z + t_coord'(1);
        ez1        = ez - t_coord'(1);
        row_wrap   = (nx == ex);
        y_step     = row_wrap && (r_pos_y < ey);
        slice_wrap = y_step && (ny == ey);
        z_step     = slice_wrap && (r_pos_z < ez1);
        z_done     = slice_wrap && (r_pos_z == ez1);

        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_pos_z      = r_pos_z;
        n_addr       = r_addr;
        n_row_skip   = r_row_skip;
        n_slice_skip = r_slice_skip;
        n_edge       = r_edge;
        n_err        = 1'b0;

        if (mode == MODE_LOAD) begin
            n_pos_x      = st_x;
            n_pos_y      = st_y;
            n_pos_z      = st_z;
            n_addr       = st_addr;
            n_row_skip   = t_addr'(sx) - dx_a;
            n_slice_skip = slice_prod[A-1:0];
            n_edge[F_XLOW]  = (st_x == '0);
            n_edge[F_XHIGH] = (st_x == sx - t_coord'(1));
            n_edge[F_YLOW]  = (st_y == '0);
            n_edge[F_YHIGH] = (st_y == sy - t_coord'(1));
            n_edge[F_ZLOW]  = (st_z == '0);
            n_edge[F_ZHIGH] = (st_z == sz - t_coord'(1));
        end else if (r_pos_x >= ex) begin
            n_err = 1'b1;
        end else begin
            n_pos_x = nx;
            n_addr  = r_addr + t_addr'(1)
                      + (y_step ? r_row_skip : '0)
                      + (z_step ? r_slice_skip : '0);
            n_edge[F_XLOW]  = 1'b0;
            n_edge[F_XHIGH] = 1'b0;
            if (row_wrap) begin
                if (y_step) begin
                    n_pos_x         = bx;
                    n_pos_y         = ny;
                    n_edge[F_YLOW]  = 1'b0;
                    n_edge[F_YHIGH] = 1'b0;
                    if (slice_wrap) begin
                        if (z_step) begin
                            n_pos_y        = by;
                            n_pos_z        = nz;
                            n_edge[F_ZLOW] = 1'b0;
                            if (nz == sz - t_coord'(1)) begin
                                n_edge[F_ZHIGH] = 1'b1;
                            end
                        end else if (z_done) begin
                            n_pos_x = ex;
                            n_pos_y = ey;
                            n_pos_z = ez;
                        end
                        // Only the low flag is checked after a wrap.
                        if (n_pos_y == '0) begin
                            n_edge[F_YLOW] = 1'b1;
                        end
                    end else if (ny == sy - t_coord'(1)) begin
                        n_edge[F_YHIGH] = 1'b1;
                    end
                end
                if (n_pos_x == '0) begin
                    n_edge[F_XLOW] = 1'b1;
                end
            end else if (nx == sx - t_coord'(1)) begin
                n_edge[F_XHIGH] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
            r_begin <= '0;
            r_end <= '0;
        end else if (cfg_accept) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VOLUME_SIZE:  r_size  <= i_cfg_data;
                CFG_REGION_BEGIN: r_begin <= i_cfg_data;
                CFG_REGION_END:   r_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_pos_z      <= '0;
            r_addr       <= '0;
            r_row_skip   <= '0;
            r_slice_skip <= '0;
            r_edge       <= '0;
        end else if (in_accept) begin
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_pos_z      <= n_pos_z;
            r_addr       <= n_addr;
            r_row_skip   <= n_row_skip;
            r_slice_skip <= n_slice_skip;
            r_edge       <= n_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_x    <= n_pos_x;
            r_out_y    <= n_pos_y;
            r_out_z    <= n_pos_z;
            r_out_addr <= n_addr;
            r_out_edge <= n_edge;
            r_out_err  <= n_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_edge, r_out_addr, r_out_z, r_out_y, r_out_x});
    assign o_m_axis_tuser  = r_out_err;

    // A refused advance leaves the walker where it was.
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && mode == MODE_ADVANCE && r_pos_x >= ex) |=>
        ($stable(r_pos_x) && $stable(r_pos_y) && $stable(r_pos_z) && $stable(r_addr)
         && $stable(r_edge)))
        else $error("refused advance changed the walker state");

    // A load never reports an error.
    a_load_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && mode == MODE_LOAD) |=> (r_out_valid && !r_out_err))
        else $error("load reported a step error");

    // The held result always mirrors the walker state.
    a_out_mirrors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_x == r_pos_x && r_out_y == r_pos_y && r_out_z == r_pos_z
                         && r_out_addr == r_addr && r_out_edge == r_edge))
        else $error("result register out of step with walker state");

    // A result that is not taken is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !in_accept)
        else $error("item accepted while result stalled");

endmodule
